[hw/rtl/nmt_pkg.sv]
package nmt_pkg;

    localparam int StoreDepth = 256;
    localparam int StoreAw    = 8;
    localparam int AccW       = 40;
    localparam int SumW       = 41;
    localparam int MagW       = 15;
    localparam int KW         = 9;
    localparam int MagDepth   = 256;
    localparam int MagAw      = 8;

    localparam logic OP_WRITE_WEIGHT = 1'b0;
    localparam logic OP_ELEMENT      = 1'b1;

    localparam logic REG_BIAS = 1'b0;

    localparam logic signed [SumW-1:0] SAT_HI = 41'sd67108863;
    localparam logic signed [SumW-1:0] SAT_LO = -41'sd67108864;
    localparam logic signed [KW-1:0]   K_MAX  = 9'sd255;
    localparam logic signed [KW-1:0]   K_MIN  = -9'sd256;

    // round(tanh(4) * 32767), the magnitude at the negative saturation point
    localparam logic [MagW-1:0] MAG_FULL = 15'd32745;

    typedef logic [MagW-1:0] mag_tab_t [0:MagDepth-1];

    typedef struct packed {
        logic            valid;
        logic [AccW-1:0] sum;
    } fin_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] value;
    } act_t;

    // restoring long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b})
            begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(tanh(m/64) * 32767) for m = 0 .. 255, exp(-2|x|) stepped in Q2.62
    function automatic mag_tab_t build_mag_tab();
        mag_tab_t          tab;
        logic [63:0]       q62_one;
        logic [63:0]       q40_one;
        logic [63:0]       term;
        logic [63:0]       e1;
        logic [63:0]       e;
        logic [63:0]       e40;
        logic [63:0]       num;
        logic [63:0]       den;
        logic [63:0]       n;
        logic [127:0]      prod;
        q62_one = 64'd1 << 62;
        q40_one = 64'd1 << 40;
        term    = q62_one;
        e1      = q62_one;
        n       = 64'd1;
        while (term != 64'd0)
        begin
            term = udiv64(term, 64'd32 * n);
            if (n[0])
            begin
                e1 = e1 - term;
            end
            else
            begin
                e1 = e1 + term;
            end
            n = n + 64'd1;
        end
        tab[0] = '0;
        e      = q62_one;
        for (int m = 1; m < MagDepth; m++)
        begin
            prod   = {64'd0, e} * {64'd0, e1};
            e      = prod[125:62];
            e40    = e >> 22;
            num    = 64'd32767 * (q40_one - e40);
            den    = q40_one + e40;
            tab[m] = MagW'(udiv64(64'd2 * num + den, 64'd2 * den));
        end
        return tab;
    endfunction

    localparam mag_tab_t MAG_TAB = build_mag_tab();

endpackage

[hw/rtl/nmt_activation.sv]
module nmt_activation (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  nmt_pkg::fin_t          fin,
    input  logic [15:0]            bias,
    output nmt_pkg::act_t          act
);

    logic signed [nmt_pkg::SumW-1:0] biased;
    logic signed [nmt_pkg::KW-1:0]   k_next;
    logic signed [nmt_pkg::KW-1:0]   k_reg;
    logic                            k_valid_reg;
    logic [nmt_pkg::MagAw-1:0]       mag_idx;
    logic [nmt_pkg::MagAw-1:0]       k_neg;
    logic [nmt_pkg::MagW-1:0]        mag;

    always_comb
    begin
        biased = $signed({fin.sum[nmt_pkg::AccW-1], fin.sum})
               + $signed({{13{bias[15]}}, bias, 12'd0});
        priority if (biased > nmt_pkg::SAT_HI)
        begin
            k_next = nmt_pkg::K_MAX;
        end
        else if (biased < nmt_pkg::SAT_LO)
        begin
            k_next = nmt_pkg::K_MIN;
        end
        else
        begin
            k_next = biased[26:18];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            k_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && fin.valid)
        begin
            k_reg <= k_next;
        end
    end

    // tanh is odd: look up |k|, restore the sign
    always_comb
    begin
        k_neg   = -k_reg[nmt_pkg::MagAw-1:0];
        mag_idx = k_reg[nmt_pkg::KW-1] ? k_neg : k_reg[nmt_pkg::MagAw-1:0];
        mag     = (k_reg == nmt_pkg::K_MIN) ? nmt_pkg::MAG_FULL : nmt_pkg::MAG_TAB[mag_idx];
        act.valid = k_valid_reg;
        act.value = k_reg[nmt_pkg::KW-1] ? -{1'b0, mag} : {1'b0, mag};
    end

endmodule

[hw/rtl/neuron_mac_tanh.sv]
// Channel  Direction  Handshake                   Payload
// cmd      in         cmd_valid / cmd_stall       opcode, weight_index, sample, last
// result   out        result_valid / result_stall activation
// apb      in         psel / penable / pready     paddr, pwdata, prdata (bias)
//
// One command per cycle when not stalled. Elements pass registers s1 and s2, then the
// accumulator; a last element's sum passes fin and k_reg to the result register.
// The weight store is a single-port synchronous RAM: one write or one read per cycle.
// Reset clears the accumulator, the element position, the bias and all valids; the weight
// store holds garbage until written. cmd_stall rises only while a result waits in the
// output register, result_stall is high and another result is ready behind it.
module neuron_mac_tanh #(
    parameter int MAX_INPUTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic        opcode,
    input  logic [7:0]  weight_index,
    input  logic [15:0] sample,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] activation
);

    localparam int PosW = $clog2(MAX_INPUTS + 1);
    localparam logic [PosW-1:0] PosMax = PosW'(MAX_INPUTS);

    logic [15:0] weight_mem [0:nmt_pkg::StoreDepth-1];

    logic                        en;
    logic                        cmd_fire;
    logic                        elem_fire;
    logic                        in_range;
    logic [PosW+7:0]             pos_ext;
    logic [nmt_pkg::StoreAw-1:0] rd_addr;

    logic [PosW-1:0]             pos_reg;
    logic [PosW-1:0]             pos_next;
    logic [15:0]                 bias_reg;

    logic                        s1_valid_reg;
    logic                        s1_add_reg;
    logic                        s1_last_reg;
    logic [15:0]                 s1_sample_reg;
    logic [15:0]                 rd_weight_reg;

    logic                        s2_valid_reg;
    logic                        s2_add_reg;
    logic                        s2_last_reg;
    logic signed [31:0]          prod_reg;

    logic [nmt_pkg::AccW-1:0]    acc_reg;
    logic [nmt_pkg::AccW-1:0]    acc_sum;
    logic                        fin_valid_reg;
    logic [nmt_pkg::AccW-1:0]    fin_sum_reg;

    nmt_pkg::fin_t               fin;
    nmt_pkg::act_t               act;

    logic                        out_valid_reg;
    logic [15:0]                 activation_reg;

    assign en        = !(act.valid && out_valid_reg && result_stall);
    assign cmd_stall = !en;
    assign cmd_fire  = cmd_valid && en;
    assign elem_fire = cmd_fire && (opcode == nmt_pkg::OP_ELEMENT);
    assign in_range  = pos_reg < PosMax;
    assign pos_ext   = {8'd0, pos_reg};
    assign rd_addr   = pos_ext[nmt_pkg::StoreAw-1:0];

    assign pready = 1'b1;
    assign prdata = (paddr[2] == nmt_pkg::REG_BIAS) ? {16'd0, bias_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == nmt_pkg::REG_BIAS))
        begin
            bias_reg <= pwdata[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire && (opcode == nmt_pkg::OP_WRITE_WEIGHT))
        begin
            weight_mem[weight_index] <= sample;
        end
        if (elem_fire)
        begin
            rd_weight_reg <= weight_mem[rd_addr];
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (elem_fire)
        begin
            if (last)
            begin
                pos_next = '0;
            end
            else if (in_range)
            begin
                pos_next = pos_reg + PosW'(1);
            end
        end
    end

    always_comb
    begin
        acc_sum = acc_reg;
        if (s2_add_reg)
        begin
            acc_sum = acc_reg + {{(nmt_pkg::AccW - 32){prod_reg[31]}}, prod_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else if (en)
        begin
            pos_reg       <= pos_next;
            s1_valid_reg  <= elem_fire;
            s2_valid_reg  <= s1_valid_reg;
            fin_valid_reg <= s2_valid_reg && s2_last_reg;
            if (s2_valid_reg)
            begin
                acc_reg <= s2_last_reg ? '0 : acc_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (elem_fire)
            begin
                s1_sample_reg <= sample;
                s1_add_reg    <= in_range;
                s1_last_reg   <= last;
            end
            if (s1_valid_reg)
            begin
                prod_reg    <= $signed(rd_weight_reg) * $signed(s1_sample_reg);
                s2_add_reg  <= s1_add_reg;
                s2_last_reg <= s1_last_reg;
            end
            if (s2_valid_reg && s2_last_reg)
            begin
                fin_sum_reg <= acc_sum;
            end
        end
    end

    assign fin.valid = fin_valid_reg;
    assign fin.sum   = fin_sum_reg;

    nmt_activation u_activation (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .fin   (fin),
        .bias  (bias_reg),
        .act   (act)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (act.valid && en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act.valid && en)
        begin
            activation_reg <= act.value;
        end
    end

    assign result_valid = out_valid_reg;
    assign activation   = activation_reg;

`ifndef ASSERT_OFF
    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (en && s2_valid_reg && s2_last_reg) |=> (acc_reg == '0))
        else $error("accumulator not cleared after last element");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PosMax)
        else $error("element position beyond limit");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (out_valid_reg && result_stall && act.valid))
        else $error("command stalled without a blocked result");

    a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (activation_reg != 16'h8000))
        else $error("activation out of range");
`endif

endmodule
